/* rtl/core/itd_pkg.sv */
package itd_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int STEP_BITS       = 8;
    localparam int RADIX_W         = 5;
    localparam int REM_W           = 4;
    localparam int CHAR_W          = 7;
    localparam int OUT_TDATA_W     = 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SHOW
    } t_state;

    // clamp the requested radix into 2..16
    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] b);
        logic [RADIX_W-1:0] r;
        r = b;
        if (b < MIN_RADIX) begin
            r = MIN_RADIX;
        end else if (b > MAX_RADIX) begin
            r = MAX_RADIX;
        end
        return r;
    endfunction

    // 0-9 then upper-case A-F
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = 7'h30 + CHAR_W'(d);
        end else begin
            c = 7'h37 + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

/* rtl/core/itd_divider.sv */
module itd_divider #(
    parameter int VALUE_WIDTH = itd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [VALUE_WIDTH-1:0]           i_dividend,
    input  logic [itd_pkg::RADIX_W-1:0]      i_radix,
    output logic                             o_done,
    output logic [VALUE_WIDTH-1:0]           o_quotient,
    output logic [itd_pkg::REM_W-1:0]        o_remainder
);

    localparam int NSTEP = (VALUE_WIDTH + itd_pkg::STEP_BITS - 1) / itd_pkg::STEP_BITS;
    localparam int PAD_W = NSTEP * itd_pkg::STEP_BITS;
    localparam int CNT_W = $clog2(NSTEP + 1);

    logic [PAD_W-1:0]                 r_quo;
    logic [PAD_W-1:0]                 n_quo;
    logic [itd_pkg::REM_W-1:0]        r_rem;
    logic [itd_pkg::REM_W-1:0]        n_rem;
    logic [itd_pkg::RADIX_W-1:0]      r_radix;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_done;
    logic [itd_pkg::RADIX_W-1:0]      partial;

    // restoring long division, STEP_BITS quotient bits per cycle
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        partial = '0;
        for (int i = 0; i < itd_pkg::STEP_BITS; i++) begin
            partial = {n_rem, n_quo[PAD_W-1]};
            n_quo   = {n_quo[PAD_W-2:0], 1'b0};
            if (partial >= r_radix) begin
                partial  = partial - r_radix;
                n_quo[0] = 1'b1;
            end
            n_rem = partial[itd_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(NSTEP);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= PAD_W'(i_dividend);
            r_rem   <= '0;
            r_radix <= i_radix;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

/* rtl/core/integer_to_digit_string.sv */
// operation: each digit is produced by one pass of the divider, then each character
// out takes a memory read, then a present state (S_READ, S_SHOW), plus any output stall
// transactions: one at a time; the division rate is set by the shared divider
// that resolves 8 quotient bits per cycle
// reset: synchronous active-low i_rst_n returns to idle with no output pending
module integer_to_digit_string #(
    parameter int VALUE_WIDTH = itd_pkg::VALUE_WIDTH_DEF,
    localparam int IN_TDATA_W = ((VALUE_WIDTH + itd_pkg::RADIX_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // value [VALUE_WIDTH-1:0], base [VALUE_WIDTH+4:VALUE_WIDTH], zero fill above
    input  logic [IN_TDATA_W-1:0]           i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // digit_char [6:0], zero fill [7]
    output logic [itd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    localparam int IDX_W = $clog2(VALUE_WIDTH);

    itd_pkg::t_state              r_state;
    itd_pkg::t_state              n_state;
    logic [itd_pkg::RADIX_W-1:0]  r_radix;
    logic [IDX_W-1:0]             r_count;
    logic [IDX_W-1:0]             r_rd_idx;
    logic [itd_pkg::REM_W-1:0]    r_rd_data;
    logic [itd_pkg::REM_W-1:0]    r_mem [VALUE_WIDTH];

    logic                         in_fire;
    logic                         out_fire;
    logic                         div_start;
    logic                         div_done;
    logic                         quo_zero;
    logic [VALUE_WIDTH-1:0]       div_dividend;
    logic [itd_pkg::RADIX_W-1:0]  div_radix;
    logic [VALUE_WIDTH-1:0]       div_quotient;
    logic [itd_pkg::REM_W-1:0]    div_remainder;
    logic [itd_pkg::RADIX_W-1:0]  in_radix;

    assign in_radix = itd_pkg::sat_radix(i_s_axis_tdata[VALUE_WIDTH +: itd_pkg::RADIX_W]);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign quo_zero = (div_quotient == '0);

    // first pass divides the input, later passes divide the last quotient
    assign div_dividend = (r_state == itd_pkg::S_IDLE) ?
                          i_s_axis_tdata[VALUE_WIDTH-1:0] : div_quotient;
    assign div_radix    = (r_state == itd_pkg::S_IDLE) ? in_radix : r_radix;

    itd_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_radix     (div_radix),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            itd_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = itd_pkg::S_DIV;
                end
            end
            itd_pkg::S_DIV: begin
                if (div_done && quo_zero) begin
                    n_state = itd_pkg::S_READ;
                end
            end
            itd_pkg::S_READ: begin
                n_state = itd_pkg::S_SHOW;
            end
            itd_pkg::S_SHOW: begin
                if (i_m_axis_tready) begin
                    n_state = (r_rd_idx == '0) ? itd_pkg::S_IDLE : itd_pkg::S_READ;
                end
            end
            default: begin
                n_state = itd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == itd_pkg::S_IDLE);
        o_m_axis_tvalid = (r_state == itd_pkg::S_SHOW);
        div_start       = in_fire ||
                          ((r_state == itd_pkg::S_DIV) && div_done && !quo_zero);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_radix <= in_radix;
            r_count <= '0;
        end else if ((r_state == itd_pkg::S_DIV) && div_done) begin
            r_count <= r_count + IDX_W'(1);
            // most significant digit is the one just produced
            if (quo_zero) begin
                r_rd_idx <= r_count;
            end
        end else if (out_fire) begin
            r_rd_idx <= r_rd_idx - IDX_W'(1);
        end
    end

    // digit buffer, filled least significant first and read back downward
    always_ff @(posedge i_clk) begin
        if ((r_state == itd_pkg::S_DIV) && div_done) begin
            r_mem[r_count] <= div_remainder;
        end
        if (r_state == itd_pkg::S_READ) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_m_axis_tdata = itd_pkg::OUT_TDATA_W'(itd_pkg::digit_to_ascii(r_rd_data));
    assign o_m_axis_tlast = (r_rd_idx == '0);

    a_busy_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while a digit is pending");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == itd_pkg::S_DIV))
        else $error("divider finished outside the division phase");

    a_digit_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (itd_pkg::RADIX_W'(r_rd_data) < r_radix))
        else $error("emitted digit not below radix");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("not ready after last digit");

endmodule

/* bench/integer_to_digit_string_test.sv */
`timescale 1ns / 1ps

module integer_to_digit_string_test;

    localparam int VW         = itd_pkg::VALUE_WIDTH_DEF;
    localparam int IN_W       = ((VW + itd_pkg::RADIX_W + 7) / 8) * 8;
    localparam int TAIL       = 200;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 235;

    typedef struct {
        logic [VW-1:0]                value;
        logic [itd_pkg::RADIX_W-1:0]  base;
        logic                         drain_first;
    } conv_req_t;

    typedef struct {
        logic [itd_pkg::CHAR_W-1:0] digit_char;
        logic                       last;
    } digit_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            o_s_axis_tready;
    logic [IN_W-1:0]                 in_data = '0;
    logic                            o_m_axis_tvalid;
    logic                            out_ready = 1'b0;
    logic [itd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tlast;

    conv_req_t pending[$];
    digit_t    digit_queue[$];

    int in_sent = 0;
    int in_taken = 0;
    int in_gap = 0;
    int out_taken = 0;
    int out_seen = 0;
    int out_stall = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    integer_to_digit_string uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (o_s_axis_tready),
        // value [63:0], base [68:64], zero fill [71:69]
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (out_ready),
        // digit_char [6:0], zero fill [7]
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // radix conversion, digits queued most significant first
    function automatic void predict_digits(input logic [VW-1:0] value,
                                           input logic [itd_pkg::RADIX_W-1:0] base);
        logic [VW-1:0] rest;
        logic [VW-1:0] radix;
        logic [3:0]    digs[64];
        int            n;
        digit_t        d;
        radix = VW'(base);
        if (base < itd_pkg::MIN_RADIX) begin
            radix = VW'(itd_pkg::MIN_RADIX);
        end else if (base > itd_pkg::MAX_RADIX) begin
            radix = VW'(itd_pkg::MAX_RADIX);
        end
        rest = value;
        n = 0;
        do begin
            digs[n] = 4'(rest % radix);
            rest = rest / radix;
            n++;
        end while (rest != 0 && n < 64);
        for (int k = n - 1; k >= 0; k--) begin
            if (digs[k] < 4'd10) begin
                d.digit_char = 7'(8'h30 + digs[k]);
            end else begin
                d.digit_char = 7'(8'h41 + digs[k] - 4'd10);
            end
            d.last = (k == 0);
            digit_queue.push_back(d);
        end
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 29) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void add_req(input logic [VW-1:0] value,
                                    input logic [itd_pkg::RADIX_W-1:0] base,
                                    input logic drain_first);
        conv_req_t r;
        r.value = value;
        r.base = base;
        r.drain_first = drain_first;
        pending.push_back(r);
    endfunction

    // sender
    always @(negedge i_clk) begin : drive
        conv_req_t req;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken == in_sent) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end else if (pending.size() != 0 && (!pending[0].drain_first ||
                         (in_taken == in_sent && digit_queue.size() == 0))) begin
                req = pending.pop_front();
                in_data <= IN_W'({req.base, req.value});
                in_valid <= 1'b1;
                in_sent = in_sent + 1;
                in_gap = draw_wait(send_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, one stall drawn per accepted character
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_taken != out_seen) begin
                out_seen = out_taken;
                out_stall = draw_wait(recv_calm);
            end
            if (out_stall > 0) begin
                out_ready <= 1'b0;
                out_stall = out_stall - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        digit_t want;
        if (i_rst_n && in_valid && o_s_axis_tready) begin
            predict_digits(in_data[VW-1:0], in_data[VW +: itd_pkg::RADIX_W]);
            in_taken = in_taken + 1;
        end
        if (i_rst_n && o_m_axis_tvalid && out_ready) begin
            out_taken = out_taken + 1;
            if (digit_queue.size() == 0) begin
                $error("unexpected transaction: digit_char %h last %b",
                       o_m_axis_tdata[itd_pkg::CHAR_W-1:0], o_m_axis_tlast);
                fail_cnt++;
            end else begin
                want = digit_queue.pop_front();
                if (o_m_axis_tdata[itd_pkg::CHAR_W-1:0] !== want.digit_char) begin
                    $error("digit_char: expected %h, got %h", want.digit_char,
                           o_m_axis_tdata[itd_pkg::CHAR_W-1:0]);
                    fail_cnt++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stim
        logic [VW-1:0]               v;
        logic [itd_pkg::RADIX_W-1:0] b;
        // directed: zero, saturated radices, full-width values, digit letters
        add_req(64'd0, 5'd10, 1'b0);
        add_req(64'd0, 5'd0, 1'b0);
        add_req('1, 5'd2, 1'b0);
        add_req('1, 5'd16, 1'b0);
        add_req('1, 5'd0, 1'b0);
        add_req('1, 5'd1, 1'b0);
        add_req('1, 5'd17, 1'b0);
        add_req('1, 5'd31, 1'b0);
        add_req(64'd1, 5'd2, 1'b0);
        add_req(64'd15, 5'd16, 1'b0);
        add_req(64'd255, 5'd16, 1'b1);
        add_req(64'd10, 5'd10, 1'b0);
        add_req(64'h8000_0000_0000_0000, 5'd2, 1'b0);
        add_req(64'h0123_4567_89AB_CDEF, 5'd16, 1'b0);
        add_req(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0);
        add_req(64'd12345, 5'd3, 1'b0);
        add_req(64'd5555555, 5'd5, 1'b0);
        add_req(64'd987654321, 5'd7, 1'b0);
        add_req(64'd80, 5'd9, 1'b0);
        add_req(64'd120, 5'd11, 1'b0);
        add_req(64'd143, 5'd12, 1'b0);
        add_req(64'd168, 5'd13, 1'b0);
        add_req(64'd195, 5'd14, 1'b0);
        add_req(64'd224, 5'd15, 1'b1);
        add_req(64'hAAAA_5555_0F0F_F0F0, 5'd4, 1'b0);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            case ($urandom_range(0, 5))
                0: v = {$urandom, $urandom};
                1: v = VW'($urandom_range(0, 40));
                2: v = VW'($urandom);
                3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                4: v = (64'd1 << $urandom_range(0, 63)) - VW'($urandom_range(0, 1));
                default: v = $urandom_range(0, 1) ? '1 : {$urandom, $urandom} | 64'h1;
            endcase
            if ($urandom_range(0, 9) == 0) begin
                b = 5'($urandom_range(0, 31));
            end else begin
                b = 5'($urandom_range(2, 16));
            end
            add_req(v, b, $urandom_range(0, 49) == 0);
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending.size() == 0 && in_taken == in_sent && digit_queue.size() == 0);
        repeat (TAIL) @(posedge i_clk);
        if (fail_cnt == 0 && digit_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* integer_to_digit_string.f */
rtl/core/itd_pkg.sv
rtl/core/itd_divider.sv
rtl/core/integer_to_digit_string.sv
bench/integer_to_digit_string_test.sv
